/* rtl/cte_pkg.sv */
package cte_pkg;

  // result kinds for the cell memory side
  typedef enum logic [2:0] {
    KIND_CELL   = 3'd0,
    KIND_CHAR   = 3'd1,
    KIND_SCROLL = 3'd2,
    KIND_CURSOR = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_t;

  // input opcodes
  localparam logic OP_PRINT = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // control characters
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // one classified item, as handed from front to back
  typedef struct packed {
    logic        has_first;   // a cell write, a backspace blank or a clear leads the results
    kind_t       first_kind;
    logic        has_scroll;
    logic [4:0]  row;
    logic [6:0]  column;
    logic [7:0]  cell_char;
    logic [7:0]  cell_colour;
    logic [10:0] cursor_position;
  } cmd_t;

endpackage

/* rtl/cte_in_if.sv */
interface cte_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] char_code;
  logic [7:0] colour;

  modport source (output valid, output opcode, output char_code, output colour, input ready);
  modport sink (input valid, input opcode, input char_code, input colour, output ready);
endinterface

/* rtl/cte_out_if.sv */
interface cte_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [4:0]  row;
  logic [6:0]  column;
  logic [7:0]  cell_char;
  logic [7:0]  cell_colour;
  logic [10:0] cursor_position;
  logic        last;

  modport source (output valid, output kind, output row, output column, output cell_char,
                  output cell_colour, output cursor_position, output last, input ready);
  modport sink (input valid, input kind, input row, input column, input cell_char,
                input cell_colour, input cursor_position, input last, output ready);
endinterface

/* rtl/cte_front.sv */
module cte_front #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic          clk,
  input  logic          rst,
  cte_in_if.sink        text,
  input  logic          q_full,
  output logic          q_push,
  output cte_pkg::cmd_t q_cmd
);
  import cte_pkg::*;

  // next tab stop for every column value, built without division
  function automatic logic [127:0][7:0] tab_table();
    logic [127:0][7:0] t;
    int stop;
    stop = TAB_STOP;
    for (int c = 0; c < 128; c++) begin
      if (c >= stop) stop = stop + TAB_STOP;
      t[c] = 8'(stop);
    end
    return t;
  endfunction

  localparam logic [127:0][7:0] TAB_NEXT = tab_table();
  localparam logic [7:0] COL_LIMIT = 8'(COLUMNS);
  localparam logic [5:0] ROW_LIMIT = 6'(ROWS - 1);
  localparam logic [6:0] COL_MUL   = 7'(COLUMNS);

  logic [6:0] cursor_column;
  logic [4:0] cursor_row;

  logic [7:0]  col_w;
  logic [5:0]  row_w;
  logic [4:0]  row_fin;
  logic [6:0]  col_fin;
  logic [11:0] pos_w;
  cmd_t        cmd;

  assign text.ready = !q_full;
  assign q_push     = text.valid && !q_full;
  assign q_cmd      = cmd;

  always_comb begin
    cmd             = '0;
    cmd.first_kind  = KIND_CELL;
    col_w           = {1'b0, cursor_column};
    row_w           = {1'b0, cursor_row};
    row_fin         = '0;
    col_fin         = '0;
    pos_w           = '0;
    if (text.opcode == OP_CLEAR) begin
      cmd.has_first  = 1'b1;
      cmd.first_kind = KIND_CLEAR;
    end else begin
      case (text.char_code)
        CH_BS: begin
          if (cursor_column != 7'd0) begin
            col_w          = col_w - 8'd1;
            cmd.has_first  = 1'b1;
            cmd.first_kind = KIND_CHAR;
            cmd.row        = cursor_row;
            cmd.column     = col_w[6:0];
          end
        end
        CH_TAB: col_w = TAB_NEXT[cursor_column];
        CH_CR:  col_w = 8'd0;
        CH_LF: begin
          col_w = 8'd0;
          row_w = row_w + 6'd1;
        end
        default: begin
          cmd.has_first   = 1'b1;
          cmd.first_kind  = KIND_CELL;
          cmd.row         = cursor_row;
          cmd.column      = cursor_column;
          cmd.cell_char   = text.char_code;
          cmd.cell_colour = text.colour;
          col_w           = col_w + 8'd1;
        end
      endcase
      // wrap at the right edge
      if (col_w >= COL_LIMIT) begin
        col_w = 8'd0;
        row_w = row_w + 6'd1;
      end
      // scroll at the bottom
      if (row_w >= ROW_LIMIT) begin
        cmd.has_scroll = 1'b1;
        if (row_w == 6'd0) col_w = 8'd0;
        else               row_w = row_w - 6'd1;
      end
      row_fin             = row_w[4:0];
      col_fin             = col_w[6:0];
      pos_w               = 12'(row_fin * COL_MUL) + {5'd0, col_fin};
      cmd.cursor_position = pos_w[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_row    <= '0;
    end else if (q_push) begin
      cursor_column <= col_fin;
      cursor_row    <= row_fin;
    end
  end

  // the stored cursor never rests on the scroll row or past the right edge
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, cursor_row} < ROW_LIMIT || ROWS < 2) && {1'b0, cursor_column} < COL_LIMIT)
    else $error("cursor left the visible area");

endmodule

/* rtl/cte_queue.sv */
module cte_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cte_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output cte_pkg::cmd_t head
);
  import cte_pkg::*;

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("command queue underflow");

endmodule

/* rtl/cte_back.sv */
module cte_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  cte_pkg::cmd_t head,
  output logic          pop,
  cte_out_if.source     screen
);
  import cte_pkg::*;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SCROLL,
    PH_CURSOR
  } phase_t;

  phase_t phase;
  phase_t eff;
  logic   load;

  logic        ovalid;
  kind_t       kind;
  logic [4:0]  row;
  logic [6:0]  column;
  logic [7:0]  cell_char;
  logic [7:0]  cell_colour;
  logic [10:0] cursor_position;
  logic        last;

  // skip the result slots that this item does not use
  always_comb begin
    eff = phase;
    if (eff == PH_FIRST && !head.has_first)   eff = PH_SCROLL;
    if (eff == PH_SCROLL && !head.has_scroll) eff = PH_CURSOR;
  end

  assign load = head_valid && (!ovalid || screen.ready);
  assign pop  = load && eff == PH_CURSOR;

  assign screen.valid           = ovalid;
  assign screen.kind            = kind;
  assign screen.row             = row;
  assign screen.column          = column;
  assign screen.cell_char       = cell_char;
  assign screen.cell_colour     = cell_colour;
  assign screen.cursor_position = cursor_position;
  assign screen.last            = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_FIRST;
      ovalid <= 1'b0;
    end else if (load) begin
      ovalid          <= 1'b1;
      row             <= '0;
      column          <= '0;
      cell_char       <= '0;
      cell_colour     <= '0;
      cursor_position <= '0;
      last            <= 1'b0;
      case (eff)
        PH_FIRST: begin
          phase       <= PH_SCROLL;
          kind        <= head.first_kind;
          row         <= head.row;
          column      <= head.column;
          cell_char   <= head.cell_char;
          cell_colour <= head.cell_colour;
        end
        PH_SCROLL: begin
          phase <= PH_CURSOR;
          kind  <= KIND_SCROLL;
        end
        default: begin
          phase           <= PH_FIRST;
          kind            <= KIND_CURSOR;
          cursor_position <= head.cursor_position;
          last            <= 1'b1;
        end
      endcase
    end else if (screen.ready) begin
      ovalid <= 1'b0;
    end
  end

  a_last_is_cursor: assert property (@(posedge clk) disable iff (rst)
    ovalid |-> (last == (kind == KIND_CURSOR)))
    else $error("last flag does not match the cursor result");

endmodule

/* rtl/text_console_cursor_engine.sv */
// channel | dir | payload                                            | handshake
// text    | in  | opcode, char_code, colour                          | valid/ready
// screen  | out | kind, row, column, cell_char, cell_colour,         | valid/ready
//         |     | cursor_position, last                              |
//
// an item gives one to three results; the result port sends one per cycle while
// screen.ready is high, so a print item that writes a cell and scrolls gives three
// results, a clear, a plain write or a blanking backspace two, other control bytes without scroll one
// the front classifies an item in the cycle it is accepted and updates the cursor
// reset (rst, synchronous) homes the cursor and empties the two-entry queue
// the front stalls only when the queue is full; the back holds its output
// register while screen.ready is low
module text_console_cursor_engine #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic      clk,
  input  logic      rst,
  cte_in_if.sink    text,
  cte_out_if.source screen
);
  import cte_pkg::*;

  // classified commands between front and back
  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  cmd_t q_in;
  cmd_t q_head;

  // front: cursor state, control character decode, wrap and scroll test
  cte_front #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .text   (text),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_in)
  );

  // short queue so a stalled result port does not block the input at once
  cte_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // back: steps through the result slots of each command
  cte_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop),
    .screen     (screen)
  );

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;
  import cte_pkg::*;

  // screen geometry, kept equal to the block's parameters
  localparam int COLS      = 80;
  localparam int ROWS_N    = 25;
  localparam int TAB_W     = 8;
  localparam int RAND_TEXT = 74;
  localparam int LIMIT     = 100000;

  // one result for the cell memory, as it should leave the block
  typedef struct {
    kind_t       kind;
    logic [4:0]  row;
    logic [6:0]  column;
    logic [7:0]  cell_char;
    logic [7:0]  cell_colour;
    logic [10:0] cursor_position;
    logic        last;
  } cell_cmd_t;

  // one row of the directed script: an item, how often to repeat it and,
  // where it is obvious, the cursor position that the last repeat must report
  typedef struct packed {
    logic        op;
    logic [7:0]  ch;
    logic [7:0]  attr;
    logic [7:0]  reps;
    logic        typed;
    logic [10:0] pos;
  } script_row_t;

  localparam int SCRIPT_LEN = 25;
  localparam script_row_t SCRIPT [0:SCRIPT_LEN-1] = '{
    '{OP_CLEAR, 8'h00, 8'h00, 8'd1,  1'b1, 11'd0},     // clear right after reset
    '{OP_PRINT, CH_BS, 8'h00, 8'd1,  1'b1, 11'd0},     // backspace at column zero
    '{OP_PRINT, 8'h41, 8'hFF, 8'd1,  1'b1, 11'd1},     // plain char, full attribute
    '{OP_PRINT, 8'hFF, 8'h00, 8'd1,  1'b1, 11'd2},     // top char code
    '{OP_PRINT, 8'h00, 8'hAA, 8'd1,  1'b1, 11'd3},     // nul prints like any byte
    '{OP_PRINT, CH_TAB, 8'h00, 8'd1, 1'b1, 11'd8},     // tab to next stop
    '{OP_PRINT, CH_BS, 8'h00, 8'd1,  1'b1, 11'd7},     // backspace blanks a cell
    '{OP_PRINT, CH_CR, 8'h00, 8'd1,  1'b1, 11'd0},     // carriage return
    '{OP_PRINT, CH_LF, 8'h00, 8'd1,  1'b1, 11'd80},    // line feed
    '{OP_PRINT, CH_TAB, 8'h00, 8'd10, 1'b1, 11'd160},  // tabs run off the line end
    '{OP_PRINT, CH_LF, 8'h00, 8'd22, 1'b1, 11'd1840},  // line feeds down to a scroll
    '{OP_PRINT, CH_TAB, 8'h00, 8'd10, 1'b1, 11'd1840}, // tab wrap on the last line
    '{OP_PRINT, 8'h78, 8'h55, 8'd80, 1'b1, 11'd1840},  // char wrap: write, scroll, cursor
    '{OP_PRINT, CH_BS, 8'h00, 8'd1,  1'b1, 11'd1840},  // backspace at column zero again
    '{OP_PRINT, 8'h7E, 8'h81, 8'd5,  1'b1, 11'd1845},
    '{OP_PRINT, CH_LF, 8'h00, 8'd1,  1'b1, 11'd1840},  // line feed scroll mid-line
    '{OP_PRINT, CH_TAB, 8'h00, 8'd1, 1'b1, 11'd1848},
    '{OP_CLEAR, 8'h00, 8'h00, 8'd1,  1'b1, 11'd0},     // clear from the last line
    '{OP_PRINT, 8'h7F, 8'h0F, 8'd1,  1'b1, 11'd1},
    '{OP_PRINT, CH_CR, 8'h00, 8'd1,  1'b1, 11'd0},
    '{OP_PRINT, 8'h0E, 8'h01, 8'd1,  1'b1, 11'd1},     // bytes next to the control codes
    '{OP_PRINT, 8'h0F, 8'h02, 8'd1,  1'b1, 11'd2},
    '{OP_PRINT, 8'h07, 8'h03, 8'd1,  1'b1, 11'd3},
    '{OP_PRINT, 8'h0B, 8'h04, 8'd1,  1'b1, 11'd4},
    '{OP_CLEAR, 8'hFF, 8'hFF, 8'd1,  1'b1, 11'd0}      // clear ignores char and attribute
  };

  logic clk;
  logic rst;
  bit   calm;           // no idling on either side while set
  int   mismatches;

  // cursor as the predictor sees it
  int cur_col;
  int cur_row;

  // results still owed by the block, oldest first
  cell_cmd_t pending_cells [$];

  cte_in_if  text_if ();
  cte_out_if cell_if ();

  text_console_cursor_engine #(
    .COLUMNS (COLS),
    .ROWS    (ROWS_N),
    .TAB_STOP(TAB_W)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .text  (text_if),
    .screen(cell_if)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  function automatic void queue_cell(input kind_t kind, input int row, input int column,
                                     input int ch, input int attr, input int pos,
                                     input logic last);
    cell_cmd_t c;
    c.kind            = kind;
    c.row             = row[4:0];
    c.column          = column[6:0];
    c.cell_char       = ch[7:0];
    c.cell_colour     = attr[7:0];
    c.cursor_position = pos[10:0];
    c.last            = last;
    pending_cells.push_back(c);
  endfunction

  // teletype behavior: works out the results of one item and moves the cursor
  function automatic void predict_text(input logic op, input logic [7:0] ch,
                                       input logic [7:0] attr);
    int col;
    int row;
    col = cur_col;
    row = cur_row;
    if (op == OP_CLEAR) begin
      queue_cell(KIND_CLEAR, 0, 0, 0, 0, 0, 1'b0);
      cur_col = 0;
      cur_row = 0;
      queue_cell(KIND_CURSOR, 0, 0, 0, 0, 0, 1'b1);
      return;
    end
    case (ch)
      CH_BS: begin
        // nothing happens at the left edge
        if (col > 0) begin
          col--;
          queue_cell(KIND_CHAR, row, col, 0, 0, 0, 1'b0);
        end
      end
      CH_TAB: col = (col / TAB_W + 1) * TAB_W;
      CH_CR:  col = 0;
      CH_LF: begin
        col = 0;
        row++;
      end
      default: begin
        queue_cell(KIND_CELL, row, col, ch, attr, 0, 1'b0);
        col++;
      end
    endcase
    // wrap past the right edge
    if (col >= COLS) begin
      col = 0;
      row++;
    end
    // the bottom line stays free: scroll once the cursor reaches it
    if (row >= ROWS_N - 1) begin
      queue_cell(KIND_SCROLL, 0, 0, 0, 0, 0, 1'b0);
      if (row == 0) col = 0;
      else          row--;
    end
    cur_col = col;
    cur_row = row;
    queue_cell(KIND_CURSOR, 0, 0, 0, 0, (row * COLS + col) % 2048, 1'b1);
  endfunction

  // offers one item, idling now and then, and predicts it once accepted;
  // valid stays high afterwards so back-to-back items need no extra step
  task automatic send_text(input logic op, input logic [7:0] ch, input logic [7:0] attr);
    while (!calm && $urandom_range(0, 99) < 25) begin
      text_if.valid <= 1'b0;
      @(posedge clk);
    end
    text_if.valid     <= 1'b1;
    text_if.opcode    <= op;
    text_if.char_code <= ch;
    text_if.colour    <= attr;
    @(posedge clk);
    while (!text_if.ready) @(posedge clk);
    predict_text(op, ch, attr);
  endtask

  // result side stalls at random, except in the calm stretch
  always @(posedge clk) begin
    if (rst) begin
      cell_if.ready <= 1'b0;
    end else begin
      cell_if.ready <= calm || ($urandom_range(0, 99) >= 25);
    end
  end

  // every accepted result against the oldest one owed
  always @(posedge clk) begin
    cell_cmd_t want;
    if (!rst && cell_if.valid && cell_if.ready) begin
      if (pending_cells.size() == 0) begin
        report_mismatch("unexpected result, kind", cell_if.kind, -1);
      end else begin
        want = pending_cells.pop_front();
        if (cell_if.kind != want.kind)
          report_mismatch("kind", cell_if.kind, want.kind);
        if (cell_if.row != want.row)
          report_mismatch("row", cell_if.row, want.row);
        if (cell_if.column != want.column)
          report_mismatch("column", cell_if.column, want.column);
        if (cell_if.cell_char != want.cell_char)
          report_mismatch("cell_char", cell_if.cell_char, want.cell_char);
        if (cell_if.cell_colour != want.cell_colour)
          report_mismatch("cell_colour", cell_if.cell_colour, want.cell_colour);
        if (cell_if.cursor_position != want.cursor_position)
          report_mismatch("cursor_position", cell_if.cursor_position,
                          want.cursor_position);
        if (cell_if.last != want.last)
          report_mismatch("last", cell_if.last, want.last);
      end
    end
  end

  // watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic       op;
    logic [7:0] ch;
    logic [7:0] attr;
    int         pick;
    cell_cmd_t  tail;

    rst                   = 1'b1;
    calm                  = 1'b0;
    mismatches            = 0;
    cur_col               = 0;
    cur_row               = 0;
    text_if.valid         = 1'b0;
    text_if.opcode        = OP_PRINT;
    text_if.char_code     = 8'h00;
    text_if.colour        = 8'h00;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed script; typed positions replace the predicted one on the last repeat
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      for (int k = 0; k < SCRIPT[i].reps; k++) begin
        send_text(SCRIPT[i].op, SCRIPT[i].ch, SCRIPT[i].attr);
        if (SCRIPT[i].typed && k == SCRIPT[i].reps - 1) begin
          tail = pending_cells.pop_back();
          tail.cursor_position = SCRIPT[i].pos;
          pending_cells.push_back(tail);
        end
      end
    end

    // random text: mostly plain bytes of any value, enough line feeds to keep scrolling,
    // a few clears
    for (int i = 0; i < RAND_TEXT; i++) begin
      calm <= (i >= 20 && i < 50);
      pick = $urandom_range(0, 99);
      op   = OP_PRINT;
      ch   = 8'($urandom_range(0, 255));
      attr = 8'($urandom_range(0, 255));
      if (pick < 3)
        op = OP_CLEAR;
      else if (pick < 15)
        ch = CH_LF;
      else if (pick < 22)
        ch = CH_TAB;
      else if (pick < 28)
        ch = CH_BS;
      else if (pick < 32)
        ch = CH_CR;
      send_text(op, ch, attr);
    end
    text_if.valid <= 1'b0;
    calm          <= 1'b0;

    // drain, then give any stray result time to show up
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/cte_pkg.sv
rtl/cte_in_if.sv
rtl/cte_out_if.sv
rtl/cte_front.sv
rtl/cte_queue.sv
rtl/cte_back.sv
rtl/text_console_cursor_engine.sv
verif/tb.sv
